// ----- rtl/cao_pkg.sv -----
// Package for the capsule/box overlap unit: payload structs, widths, register codes.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none
package cao_pkg;
    localparam int CoordBits  = 24;
    localparam int Iterations = 32;
    localparam int TBits      = 33;      // Q0.32 plus the 1.0 bit
    localparam int DsqBits    = 52;
    localparam int SqLimitLog = 26;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0, REG_MIN_Y = 3'd1, REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3, REG_MAX_Y = 3'd4, REG_MAX_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CoordBits-1:0] end_a_x;
        logic [CoordBits-1:0] end_a_y;
        logic [CoordBits-1:0] end_a_z;
        logic [CoordBits-1:0] end_b_x;
        logic [CoordBits-1:0] end_b_y;
        logic [CoordBits-1:0] end_b_z;
        logic [CoordBits-2:0] radius;
    } t_in;

    typedef struct packed {
        logic               overlap;
        logic [DsqBits-1:0] distance_sq;
    } t_out;
endpackage
`default_nettype wire

// ----- rtl/capsule_aabb_overlap_unit.sv -----
// Capsule versus box overlap: unrolled ternary search, one query per cycle while no result is held.
// Stages from input transfer to result: one entry stage, five per search step (four
// distance stages, one bound update), four for the final probe. The whole chain holds
// while a result waits.
// Synchronous active-low reset clears valid bits and box registers to 0.
// Depends on cao_pkg, cao_step, cao_dist.
`timescale 1ns / 1ps
`default_nettype none
module capsule_aabb_overlap_unit #(
    parameter int ITERATIONS = cao_pkg::Iterations
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire cao_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output cao_pkg::t_out      o_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cao_pkg::*;
    localparam int Depth = 5 * ITERATIONS + 4 + 1;   // steps, final probe, entry

    logic signed [CoordBits-1:0] r_mn [3];
    logic signed [CoordBits-1:0] r_mx [3];
    logic [Depth-1:0]  r_vld;
    logic              adv;
    t_reg_idx          widx;

    assign pready = 1'b1;
    assign widx   = t_reg_idx'(paddr[4:2]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin r_mn[k] <= '0; r_mx[k] <= '0; end
        end else if (psel && penable && pwrite) begin
            case (widx)
                REG_MIN_X: r_mn[0] <= pwdata[CoordBits-1:0];
                REG_MIN_Y: r_mn[1] <= pwdata[CoordBits-1:0];
                REG_MIN_Z: r_mn[2] <= pwdata[CoordBits-1:0];
                REG_MAX_X: r_mx[0] <= pwdata[CoordBits-1:0];
                REG_MAX_Y: r_mx[1] <= pwdata[CoordBits-1:0];
                REG_MAX_Z: r_mx[2] <= pwdata[CoordBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_MIN_X: prdata = 32'(r_mn[0]);
            REG_MIN_Y: prdata = 32'(r_mn[1]);
            REG_MIN_Z: prdata = 32'(r_mn[2]);
            REG_MAX_X: prdata = 32'(r_mx[0]);
            REG_MAX_Y: prdata = 32'(r_mx[1]);
            REG_MAX_Z: prdata = 32'(r_mx[2]);
            default:   prdata = '0;
        endcase
    end

    // Whole pipe advances unless a finished result is held.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[Depth-2:0], i_valid};
    end

    // Entry stage: capture endpoint A, AB, radius.
    logic signed [CoordBits-1:0] r_a0  [3];
    logic signed [CoordBits:0]   r_ab0 [3];
    logic        [CoordBits-2:0] r_r0;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a0[0] <= i_data.end_a_x;
            r_a0[1] <= i_data.end_a_y;
            r_a0[2] <= i_data.end_a_z;
            r_ab0[0] <= (CoordBits+1)'($signed(i_data.end_b_x))
                      - (CoordBits+1)'($signed(i_data.end_a_x));
            r_ab0[1] <= (CoordBits+1)'($signed(i_data.end_b_y))
                      - (CoordBits+1)'($signed(i_data.end_a_y));
            r_ab0[2] <= (CoordBits+1)'($signed(i_data.end_b_z))
                      - (CoordBits+1)'($signed(i_data.end_a_z));
            r_r0 <= i_data.radius;
        end
    end

    // Chain of search steps; A, AB, radius ride a delay line alongside.
    logic signed [CoordBits-1:0] a_s  [ITERATIONS+1][3];
    logic signed [CoordBits:0]   ab_s [ITERATIONS+1][3];
    logic        [CoordBits-2:0] r_s  [ITERATIONS+1];
    logic        [TBits-1:0]     lo_s [ITERATIONS+1];
    logic        [TBits-1:0]     hi_s [ITERATIONS+1];

    assign a_s[0]  = r_a0;
    assign ab_s[0] = r_ab0;
    assign r_s[0]  = r_r0;
    assign lo_s[0] = '0;
    assign hi_s[0] = TBits'(1) << 32;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_step
        logic signed [CoordBits-1:0] r_ad  [5][3];
        logic signed [CoordBits:0]   r_abd [5][3];
        logic        [CoordBits-2:0] r_rd  [5];
        cao_step u_step (
            .i_clk(i_clk), .i_en(adv), .i_a(a_s[g]), .i_ab(ab_s[g]),
            .i_lo(lo_s[g]), .i_hi(hi_s[g]), .i_mn(r_mn), .i_mx(r_mx),
            .o_lo(lo_s[g+1]), .o_hi(hi_s[g+1]));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ad[0] <= a_s[g]; r_abd[0] <= ab_s[g]; r_rd[0] <= r_s[g];
                for (int k = 1; k < 5; k++) begin
                    r_ad[k] <= r_ad[k-1]; r_abd[k] <= r_abd[k-1]; r_rd[k] <= r_rd[k-1];
                end
            end
        end
        assign a_s[g+1]  = r_ad[4];
        assign ab_s[g+1] = r_abd[4];
        assign r_s[g+1]  = r_rd[4];
    end

    // Final probe at the interval midpoint; square the radius alongside.
    logic [DsqBits-1:0]          dsq;
    logic [TBits:0]              mid_sum;
    logic [CoordBits-2:0]        r_rf [3];
    logic [2*(CoordBits-1)-1:0]  r_rsq;
    assign mid_sum = (TBits+1)'(lo_s[ITERATIONS]) + (TBits+1)'(hi_s[ITERATIONS]);
    cao_dist u_final (
        .i_clk(i_clk), .i_en(adv), .i_a(a_s[ITERATIONS]), .i_ab(ab_s[ITERATIONS]),
        .i_t(mid_sum[TBits:1]), .i_mn(r_mn), .i_mx(r_mx), .o_dsq(dsq));
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rf[0] <= r_s[ITERATIONS]; r_rf[1] <= r_rf[0]; r_rf[2] <= r_rf[1];
            r_rsq   <= r_rf[2] * r_rf[2];
        end
    end

    assign o_data.distance_sq = dsq;
    assign o_data.overlap     = dsq <= DsqBits'(r_rsq);

    // Checks.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while held");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready mismatch");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid bits moved during stall");
endmodule
`default_nettype wire

// ----- rtl/cao_dist.sv -----
// Pipelined squared distance from point A + AB*t to the box: 4 register stages.
// Depends on cao_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cao_dist (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [cao_pkg::CoordBits-1:0] i_a    [3],
    input  wire logic signed [cao_pkg::CoordBits:0]   i_ab   [3],
    input  wire logic        [cao_pkg::TBits-1:0]     i_t,
    input  wire logic signed [cao_pkg::CoordBits-1:0] i_mn   [3],
    input  wire logic signed [cao_pkg::CoordBits-1:0] i_mx   [3],
    output logic             [cao_pkg::DsqBits-1:0]   o_dsq
);
    import cao_pkg::*;
    localparam int PW = CoordBits + 3;   // point width, holds any A + step
    localparam int MW = CoordBits + 1;   // magnitude of AB
    localparam int DW = PW + 1;

    logic signed [CoordBits-1:0]  r_a1 [3];
    logic        [MW-1:0]         r_mag [3];
    logic                         r_neg [3];
    logic        [TBits-1:0]      r_t1;
    logic signed [PW-1:0]         r_p   [3];
    logic        [SqLimitLog:0]   r_m   [3];   // top bit marks saturated
    logic        [DsqBits-1:0]    r_dsq;

    // Stage 1: split AB into sign and magnitude, hold A and t.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a1[k]  <= i_a[k];
                r_neg[k] <= i_ab[k][CoordBits];
                r_mag[k] <= i_ab[k][CoordBits] ? MW'(-i_ab[k]) : MW'(i_ab[k]);
            end
            r_t1 <= i_t;
        end
    end

    // Stage 2: scale the step by t, truncate towards zero, add to A.
    always_ff @(posedge i_clk) begin
        logic [MW+TBits-1:0] prod;
        logic [MW:0]         q;
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                prod = (MW+TBits)'(r_mag[k]) * (MW+TBits)'(r_t1);
                q    = (MW+1)'(prod >> 32);
                r_p[k] <= PW'(r_a1[k]) + (r_neg[k] ? -PW'(q) : PW'(q));
            end
        end
    end

    // Stage 3: clamp per axis (min wins) and form difference magnitudes.
    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] c;
        logic signed [DW-1:0] d;
        logic        [DW-1:0] mg;
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                c  = (r_p[k] < PW'(i_mx[k])) ? r_p[k] : PW'(i_mx[k]);
                c  = (PW'(i_mn[k]) > c) ? PW'(i_mn[k]) : c;
                d  = DW'(r_p[k]) - DW'(c);
                mg = d[DW-1] ? DW'(-d) : DW'(d);
                r_m[k] <= (mg >= DW'(1 << SqLimitLog)) ? {1'b1, SqLimitLog'(0)}
                                                       : (SqLimitLog+1)'(mg);
            end
        end
    end

    // Stage 4: square and sum with saturation.
    always_ff @(posedge i_clk) begin
        logic [DsqBits:0]          s;
        logic [2*SqLimitLog-1:0]   sq;
        if (i_en) begin
            s = '0;
            for (int k = 0; k < 3; k++) begin
                sq = r_m[k][SqLimitLog-1:0] * r_m[k][SqLimitLog-1:0];
                if (r_m[k][SqLimitLog]) s = {1'b0, {DsqBits{1'b1}}};
                else s = s + (DsqBits+1)'(sq);
                if (s[DsqBits]) s = {1'b0, {DsqBits{1'b1}}};
            end
            r_dsq <= DsqBits'(s);
        end
    end
    assign o_dsq = r_dsq;
endmodule
`default_nettype wire

// ----- rtl/cao_step.sv -----
// One ternary search step: probe offsets, two distance pipes, registered bound update.
// Depends on cao_pkg and cao_dist.
`timescale 1ns / 1ps
`default_nettype none
module cao_step (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [cao_pkg::CoordBits-1:0] i_a   [3],
    input  wire logic signed [cao_pkg::CoordBits:0]   i_ab  [3],
    input  wire logic        [cao_pkg::TBits-1:0]     i_lo,
    input  wire logic        [cao_pkg::TBits-1:0]     i_hi,
    input  wire logic signed [cao_pkg::CoordBits-1:0] i_mn  [3],
    input  wire logic signed [cao_pkg::CoordBits-1:0] i_mx  [3],
    output logic             [cao_pkg::TBits-1:0]     o_lo,
    output logic             [cao_pkg::TBits-1:0]     o_hi
);
    import cao_pkg::*;
    localparam int Lat        = 4;
    localparam int RecipShift = 35;
    localparam int PBits      = 2 * (TBits + 1);
    localparam logic [TBits:0] ThirdRecip = 34'h2_AAAA_AAAB;   // (2^35 + 1) / 3

    logic [TBits-1:0] m1, m2, d;
    logic [TBits:0]   d2;
    logic [PBits-1:0] p1, p2;
    logic [TBits-1:0] r_m1 [Lat];
    logic [TBits-1:0] r_m2 [Lat];
    logic [TBits-1:0] r_lo [Lat];
    logic [TBits-1:0] r_hi [Lat];
    logic [TBits-1:0] r_nlo, r_nhi;
    logic [DsqBits-1:0] ds1, ds2;

    // Thirds by reciprocal constant; exact for operands below 2^35.
    assign d  = i_hi - i_lo;
    assign d2 = {d, 1'b0};
    assign p1 = PBits'(d)  * PBits'(ThirdRecip);
    assign p2 = PBits'(d2) * PBits'(ThirdRecip);
    assign m1 = i_lo + TBits'(p1 >> RecipShift);
    assign m2 = i_lo + TBits'(p2 >> RecipShift);

    cao_dist u_d1 (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_a), .i_ab(i_ab), .i_t(m1),
        .i_mn(i_mn), .i_mx(i_mx), .o_dsq(ds1));
    cao_dist u_d2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_a), .i_ab(i_ab), .i_t(m2),
        .i_mn(i_mn), .i_mx(i_mx), .o_dsq(ds2));

    // Hold the bounds alongside the distance pipes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1[0] <= m1; r_m2[0] <= m2; r_lo[0] <= i_lo; r_hi[0] <= i_hi;
            for (int k = 1; k < Lat; k++) begin
                r_m1[k] <= r_m1[k-1]; r_m2[k] <= r_m2[k-1];
                r_lo[k] <= r_lo[k-1]; r_hi[k] <= r_hi[k-1];
            end
        end
    end

    // Ties move the lower bound.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (ds1 < ds2) begin
                r_nlo <= r_lo[Lat-1];
                r_nhi <= r_m2[Lat-1];
            end else begin
                r_nlo <= r_m1[Lat-1];
                r_nhi <= r_hi[Lat-1];
            end
        end
    end
    assign o_lo = r_nlo;
    assign o_hi = r_nhi;
endmodule
`default_nettype wire
